// ===== sv/ptwp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptwp_pkg
// Shared widths, codes, reset values and types of the page translation block.
// ----------------------------------------------------------------------------
package ptwp_pkg;

  localparam int              TABLE_ENTRIES_DEF = 16;
  localparam longint unsigned RAM_BYTES_DEF     = 64'd1048576;

  localparam int ADDR_W    = 32;
  localparam int PAGE_W    = 20;
  localparam int OFS_W     = 12;
  localparam int OP_W      = 2;
  localparam int KIND_W    = 2;
  localparam int PERM_W    = 3;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 32;

  localparam logic [OP_W-1:0] OP_TRANSLATE = 2'd0;
  localparam logic [OP_W-1:0] OP_MAP       = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR     = 2'd2;
  localparam logic [OP_W-1:0] OP_PAGING    = 2'd3;

  localparam logic [KIND_W-1:0] KIND_FETCH = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_STORE = 2'd2;

  localparam int PERM_READ_BIT  = 0;
  localparam int PERM_WRITE_BIT = 1;
  localparam int PERM_EXEC_BIT  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_DEV_BASE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALIAS_BASE = 2'd1;

  localparam logic [CFG_W-1:0] DEV_BASE_RST   = 32'hFFFF_0000;
  localparam logic [CFG_W-1:0] ALIAS_BASE_RST = 32'h8000_0000;

  typedef struct packed {
    logic              map_en;
    logic              clear_en;
    logic              paging_wr;
    logic              paging_val;
    logic [PAGE_W-1:0] ppn;
    logic [PERM_W-1:0] perms;
  } tbl_upd_t;

  typedef struct packed {
    logic              hit;
    logic              full;
    logic [PAGE_W-1:0] ppn;
    logic [PERM_W-1:0] perms;
  } tbl_rsp_t;

endpackage

// ===== sv/ptwp_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptwp_in_if
// Request channel: one operation per item.
// ----------------------------------------------------------------------------
interface ptwp_in_if;
  logic                            valid;
  logic                            ready;
  logic [ptwp_pkg::OP_W-1:0]       opcode;
  logic [ptwp_pkg::ADDR_W-1:0]     address;
  logic [ptwp_pkg::KIND_W-1:0]     access_kind;
  logic [ptwp_pkg::PAGE_W-1:0]     virt_pg;
  logic [ptwp_pkg::PAGE_W-1:0]     phys_pg;
  logic                            may_read;
  logic                            may_write;
  logic                            may_execute;
  logic                            enable_paging;

  modport source (
    output valid, opcode, address, access_kind, virt_pg, phys_pg,
           may_read, may_write, may_execute, enable_paging,
    input  ready
  );
  modport sink (
    input  valid, opcode, address, access_kind, virt_pg, phys_pg,
           may_read, may_write, may_execute, enable_paging,
    output ready
  );
endinterface

// ===== sv/ptwp_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptwp_out_if
// Result channel: one item per request.
// ----------------------------------------------------------------------------
interface ptwp_out_if;
  logic                        valid;
  logic                        ready;
  logic [ptwp_pkg::ADDR_W-1:0] translated_address;
  logic                        access_ok;
  logic                        xlat_fault;
  logic                        map_dropped;

  modport source (
    output valid, translated_address, access_ok, xlat_fault, map_dropped,
    input  ready
  );
  modport sink (
    input  valid, translated_address, access_ok, xlat_fault, map_dropped,
    output ready
  );
endinterface

// ===== sv/ptwp_cfg_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptwp_cfg_if
// Register write channel.
// ----------------------------------------------------------------------------
interface ptwp_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [ptwp_pkg::CFG_IDX_W-1:0] index;
  logic [ptwp_pkg::CFG_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/ptwp_cfg_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptwp_cfg_regs
// Device base and alias window base registers.
// ----------------------------------------------------------------------------
module ptwp_cfg_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  ptwp_cfg_if.sink                    cfg_if,
  output logic [ptwp_pkg::CFG_W-1:0]  dev_base,
  output logic [ptwp_pkg::CFG_W-1:0]  alias_base
);

  logic [ptwp_pkg::CFG_W-1:0] dev_base_r;
  logic [ptwp_pkg::CFG_W-1:0] alias_base_r;

  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_base_r   <= ptwp_pkg::DEV_BASE_RST;
      alias_base_r <= ptwp_pkg::ALIAS_BASE_RST;
    end else if (cfg_if.valid) begin
      case (cfg_if.index)
        ptwp_pkg::CFG_DEV_BASE:   dev_base_r   <= cfg_if.data;
        ptwp_pkg::CFG_ALIAS_BASE: alias_base_r <= cfg_if.data;
        default: ;
      endcase
    end
  end

  assign dev_base   = dev_base_r;
  assign alias_base = alias_base_r;

endmodule

// ===== sv/ptwp_range_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptwp_range_chk
// Physical target check: device space, low RAM window or alias window.
// ----------------------------------------------------------------------------
module ptwp_range_chk #(
  parameter longint unsigned RAM_BYTES = ptwp_pkg::RAM_BYTES_DEF
) (
  input  logic [ptwp_pkg::ADDR_W-1:0] addr,
  input  logic [ptwp_pkg::CFG_W-1:0]  dev_base,
  input  logic [ptwp_pkg::CFG_W-1:0]  alias_base,
  output logic                        target_ok
);

  localparam logic [ptwp_pkg::ADDR_W:0] RAM_SIZE = (ptwp_pkg::ADDR_W+1)'(RAM_BYTES);

  logic [ptwp_pkg::ADDR_W:0] addr_x;
  logic [ptwp_pkg::ADDR_W:0] base_x;
  logic [ptwp_pkg::ADDR_W:0] win_end;

  // window end kept one bit wider so it never wraps
  assign addr_x  = {1'b0, addr};
  assign base_x  = {1'b0, alias_base};
  assign win_end = base_x + RAM_SIZE;

  assign target_ok = (addr >= dev_base) || (addr_x < RAM_SIZE) ||
                     ((addr_x >= base_x) && (addr_x < win_end));

endmodule

// ===== sv/ptwp_table.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptwp_table
// Fully associative page table with lookup, map, clear and paging flag.
// ----------------------------------------------------------------------------
module ptwp_table #(
  parameter int TABLE_ENTRIES = ptwp_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [ptwp_pkg::PAGE_W-1:0] key,
  input  ptwp_pkg::tbl_upd_t          upd,
  output ptwp_pkg::tbl_rsp_t          rsp,
  output logic                        paging_on
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  logic [TABLE_ENTRIES-1:0]   valid_r;
  logic [ptwp_pkg::PAGE_W-1:0] vpn_r  [TABLE_ENTRIES];
  logic [ptwp_pkg::PAGE_W-1:0] ppn_r  [TABLE_ENTRIES];
  logic [ptwp_pkg::PERM_W-1:0] perm_r [TABLE_ENTRIES];
  logic                        paging_r;

  logic [TABLE_ENTRIES-1:0] match;
  logic                     hit;
  logic                     free_any;
  logic [IDX_W-1:0]         hit_idx;
  logic [IDX_W-1:0]         free_idx;
  logic [IDX_W-1:0]         wr_idx;
  logic                     wr_en;

  always_comb begin
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      match[i] = valid_r[i] && (vpn_r[i] == key);
    end
  end

  // lowest index wins
  always_comb begin
    hit      = 1'b0;
    free_any = 1'b0;
    hit_idx  = '0;
    free_idx = '0;
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit     = 1'b1;
        hit_idx = IDX_W'(i);
      end
      if (!valid_r[i]) begin
        free_any = 1'b1;
        free_idx = IDX_W'(i);
      end
    end
  end

  assign wr_idx = hit ? hit_idx : free_idx;
  assign wr_en  = upd.map_en && (hit || free_any);

  assign rsp.hit   = hit;
  assign rsp.full  = !free_any;
  assign rsp.ppn   = ppn_r[hit_idx];
  assign rsp.perms = perm_r[hit_idx];
  assign paging_on = paging_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      paging_r <= 1'b0;
    end else begin
      if (upd.clear_en) begin
        valid_r  <= '0;
        paging_r <= 1'b0;
      end else if (upd.paging_wr) begin
        paging_r <= upd.paging_val;
      end else if (wr_en) begin
        valid_r[wr_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      vpn_r[wr_idx]  <= key;
      ppn_r[wr_idx]  <= upd.ppn;
      perm_r[wr_idx] <= upd.perms;
    end
  end

`ifndef SYNTHESIS
  a_no_dup_page: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(match))
    else $error("page mapped in more than one entry");

  a_map_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en && !upd.clear_en |=> valid_r != '0)
    else $error("map did not leave a valid entry");
`endif

endmodule

// ===== sv/page_translation_with_permissions.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_translation_with_permissions
// Page translation with per-page read, write and execute permissions.
// ----------------------------------------------------------------------------
// The block takes one item per clock while the output is not stalled, and
// returns one result item per item, in order. An item is captured in an input
// register, the table lookup, permission check and target range check run in
// one combinational pass, and the result lands in an output register.
// Throughput is one item per clock when not stalled, set by the single table
// lookup and update in that pass. Map, clear and set paging take effect for the
// very next item. Output back-pressure stalls the input register; input is still
// accepted while a result waits as long as the input register is free. Registers
// are to be written through the configuration port while idle; the block itself does not enforce it.
module page_translation_with_permissions #(
  parameter int              TABLE_ENTRIES = ptwp_pkg::TABLE_ENTRIES_DEF,
  parameter longint unsigned RAM_BYTES     = ptwp_pkg::RAM_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  ptwp_in_if.sink    in_if,
  ptwp_out_if.source out_if,
  ptwp_cfg_if.sink   cfg_if
);

  logic                          s1_valid_r;
  logic [ptwp_pkg::OP_W-1:0]     s1_op_r;
  logic [ptwp_pkg::ADDR_W-1:0]   s1_addr_r;
  logic [ptwp_pkg::KIND_W-1:0]   s1_kind_r;
  logic [ptwp_pkg::PAGE_W-1:0]   s1_vpn_r;
  logic [ptwp_pkg::PAGE_W-1:0]   s1_ppn_r;
  logic [ptwp_pkg::PERM_W-1:0]   s1_perm_r;
  logic                          s1_en_r;

  logic                          out_valid_r;
  logic [ptwp_pkg::ADDR_W-1:0]   out_taddr_r;
  logic                          out_ok_r;
  logic                          out_fault_r;
  logic                          out_dropped_r;

  logic [ptwp_pkg::ADDR_W-1:0]   res_taddr_nxt;
  logic                          res_ok_nxt;
  logic                          res_fault_nxt;
  logic                          res_dropped_nxt;

  logic                          in_fire;
  logic                          s1_go;
  logic [ptwp_pkg::CFG_W-1:0]    dev_base;
  logic [ptwp_pkg::CFG_W-1:0]    alias_base;
  logic [ptwp_pkg::PAGE_W-1:0]   key;
  ptwp_pkg::tbl_upd_t            upd;
  ptwp_pkg::tbl_rsp_t            rsp;
  logic                          paging_on;
  logic                          perm_ok;
  logic                          fault;
  logic [ptwp_pkg::ADDR_W-1:0]   phys;
  logic                          target_ok;

  assign s1_go       = s1_valid_r && (!out_valid_r || out_if.ready);
  assign in_if.ready = !s1_valid_r || s1_go;
  assign in_fire     = in_if.valid && in_if.ready;

  ptwp_cfg_regs u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_if     (cfg_if),
    .dev_base   (dev_base),
    .alias_base (alias_base)
  );

  assign key = (s1_op_r == ptwp_pkg::OP_MAP) ? s1_vpn_r
             : s1_addr_r[ptwp_pkg::ADDR_W-1 -: ptwp_pkg::PAGE_W];

  assign upd.map_en     = s1_go && (s1_op_r == ptwp_pkg::OP_MAP);
  assign upd.clear_en   = s1_go && (s1_op_r == ptwp_pkg::OP_CLEAR);
  assign upd.paging_wr  = s1_go && (s1_op_r == ptwp_pkg::OP_PAGING);
  assign upd.paging_val = s1_en_r;
  assign upd.ppn        = s1_ppn_r;
  assign upd.perms      = s1_perm_r;

  ptwp_table #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_table (
    .clk       (clk),
    .rst_n     (rst_n),
    .key       (key),
    .upd       (upd),
    .rsp       (rsp),
    .paging_on (paging_on)
  );

  always_comb begin
    case (s1_kind_r)
      ptwp_pkg::KIND_FETCH: perm_ok = rsp.perms[ptwp_pkg::PERM_EXEC_BIT];
      ptwp_pkg::KIND_LOAD:  perm_ok = rsp.perms[ptwp_pkg::PERM_READ_BIT];
      ptwp_pkg::KIND_STORE: perm_ok = rsp.perms[ptwp_pkg::PERM_WRITE_BIT];
      default:              perm_ok = 1'b0;
    endcase
  end

  assign fault = paging_on && (!rsp.hit || !perm_ok);
  assign phys  = paging_on ? {rsp.ppn, s1_addr_r[ptwp_pkg::OFS_W-1:0]} : s1_addr_r;

  ptwp_range_chk #(
    .RAM_BYTES (RAM_BYTES)
  ) u_range (
    .addr       (phys),
    .dev_base   (dev_base),
    .alias_base (alias_base),
    .target_ok  (target_ok)
  );

  always_comb begin
    res_taddr_nxt   = '0;
    res_ok_nxt      = 1'b0;
    res_fault_nxt   = 1'b0;
    res_dropped_nxt = 1'b0;
    case (s1_op_r)
      ptwp_pkg::OP_TRANSLATE: begin
        res_fault_nxt = fault;
        if (!fault) begin
          res_taddr_nxt = phys;
          res_ok_nxt    = target_ok;
        end
      end
      ptwp_pkg::OP_MAP: begin
        res_dropped_nxt = !rsp.hit && rsp.full;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (s1_go) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_go) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op_r   <= in_if.opcode;
      s1_addr_r <= in_if.address;
      s1_kind_r <= in_if.access_kind;
      s1_vpn_r  <= in_if.virt_pg;
      s1_ppn_r  <= in_if.phys_pg;
      s1_perm_r <= {in_if.may_execute, in_if.may_write, in_if.may_read};
      s1_en_r   <= in_if.enable_paging;
    end
    if (s1_go) begin
      out_taddr_r   <= res_taddr_nxt;
      out_ok_r      <= res_ok_nxt;
      out_fault_r   <= res_fault_nxt;
      out_dropped_r <= res_dropped_nxt;
    end
  end

  assign out_if.valid              = out_valid_r;
  assign out_if.translated_address = out_taddr_r;
  assign out_if.access_ok          = out_ok_r;
  assign out_if.xlat_fault         = out_fault_r;
  assign out_if.map_dropped        = out_dropped_r;

`ifndef SYNTHESIS
  a_fault_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_fault_r |-> (out_taddr_r == '0) && !out_ok_r && !out_dropped_r)
    else $error("faulting result carries address or status");

  a_clear_paging_off: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go && (s1_op_r == ptwp_pkg::OP_CLEAR) |=> !paging_on)
    else $error("clear left paging on");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_if.ready)
    else $error("input stalled with empty result register");

  a_fault_needs_paging: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go && res_fault_nxt |-> paging_on)
    else $error("page fault with paging off");
`endif

endmodule
